/* src/pcm_frame_linear_resampler_top_assert.svh */
// Assertion macros used by the resampler controller.
`ifndef PCM_FRAME_LINEAR_RESAMPLER_TOP_ASSERT_SVH
`define PCM_FRAME_LINEAR_RESAMPLER_TOP_ASSERT_SVH

// Checked only out of reset.
`define PFLR_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Checked on every edge, reset included.
`define PFLR_ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

/* src/pflr_pkg.sv */
// Shared constants and control types of the PCM frame linear resampler.
package pflr_pkg;

    localparam int unsigned PhaseW   = 23;
    localparam int unsigned StepW    = 22;
    localparam int unsigned CntW     = 6;
    localparam int unsigned CfgIdxW  = 8;
    localparam int unsigned CfgDataW = 32;

    localparam logic [PhaseW-1:0] ONE_FP   = 23'h01_0000;
    localparam logic [StepW-1:0]  MIN_STEP = 22'd1024;
    localparam logic [CntW-1:0]   CNT_LAST = 6'd63;

    localparam logic [CfgIdxW-1:0] REG_SAMPLE_DEPTH    = 8'd0;
    localparam logic [CfgIdxW-1:0] REG_SOURCE_CHANNELS = 8'd1;
    localparam logic [CfgIdxW-1:0] REG_STEREO_OUT      = 8'd2;
    localparam logic [CfgIdxW-1:0] REG_PHASE_STEP      = 8'd3;

    localparam logic [1:0] DEPTH_8  = 2'd0;
    localparam logic [1:0] DEPTH_16 = 2'd1;
    localparam logic [1:0] DEPTH_24 = 2'd2;
    localparam logic [1:0] DEPTH_32 = 2'd3;

    typedef struct packed {
        logic load;
        logic emit;
        logic cfg_wr;
    } t_dp_cmd;

    typedef struct packed {
        logic primed;
        logic phase_lt_one;
        logic last;
    } t_dp_status;

endpackage

/* src/pflr_datapath.sv */
// Datapath: configuration registers, sample decode, window, phase and interpolation.
module pflr_datapath
    import pflr_pkg::*;
(
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  t_dp_cmd                    i_cmd,
    input  logic [CfgIdxW-1:0]         i_cfg_index,
    input  logic [CfgDataW-1:0]        i_cfg_data,
    input  logic [31:0]                i_left_raw,
    input  logic [31:0]                i_right_raw,
    output t_dp_status                 o_status,
    output logic signed [15:0]         o_out_left,
    output logic signed [15:0]         o_out_right,
    output logic                       o_last
);

    function automatic logic signed [15:0] f_decode(input logic [1:0] depth,
                                                    input logic [31:0] raw);
        logic signed [15:0] v;
        unique case (depth)
            DEPTH_8:  v = {~raw[7], raw[6:0], 8'h00};
            DEPTH_16: v = raw[15:0];
            DEPTH_24: v = raw[23:8];
            DEPTH_32: v = raw[31:16];
            default:  v = raw[15:0];
        endcase
        return v;
    endfunction

    // p + floor((n - p) * t / 256)
    function automatic logic signed [15:0] f_lerp(input logic signed [15:0] p,
                                                  input logic signed [15:0] n,
                                                  input logic [7:0] t);
        logic signed [16:0] d;
        logic signed [25:0] x;
        logic signed [17:0] sh;
        d  = 17'(n) - 17'(p);
        x  = 26'(d) * 26'($signed({1'b0, t}));
        sh = 18'(x >>> 8);
        return p + sh[15:0];
    endfunction

    logic [1:0]          r_sample_depth;
    logic [1:0]          r_source_channels;
    logic                r_stereo_out;
    logic [StepW-1:0]    r_phase_step;

    logic                r_primed;
    logic                r_have_pair;
    logic [PhaseW-1:0]   r_phase;
    logic [CntW-1:0]     r_cnt;
    logic signed [15:0]  r_prev_l, r_prev_r, r_next_l, r_next_r;
    logic signed [15:0]  r_out_l, r_out_r;
    logic                r_last;

    logic signed [15:0]  w_a, w_b, w_l, w_r, w_mono;
    logic signed [16:0]  w_sum, w_sum_adj;
    logic [StepW-1:0]    w_step;
    logic [PhaseW-1:0]   w_phase_nx;
    logic                w_cfg_hit;

    always_comb begin
        w_a       = f_decode(r_sample_depth, i_left_raw);
        w_b       = f_decode(r_sample_depth, i_right_raw);
        w_sum     = 17'(w_a) + 17'(w_b);
        // average truncating toward zero
        w_sum_adj = w_sum + 17'(w_sum[16] & w_sum[0]);
        w_mono    = 16'(w_sum_adj >>> 1);
        if (!r_source_channels[1]) begin
            w_l = w_a;
            w_r = w_a;
        end else if (!r_stereo_out) begin
            w_l = w_mono;
            w_r = w_mono;
        end else begin
            w_l = w_a;
            w_r = w_b;
        end
        w_step     = (r_phase_step < MIN_STEP) ? MIN_STEP : r_phase_step;
        w_phase_nx = r_phase + PhaseW'(w_step);
        w_cfg_hit  = i_cmd.cfg_wr && (i_cfg_index == REG_SAMPLE_DEPTH ||
                     i_cfg_index == REG_SOURCE_CHANNELS || i_cfg_index == REG_STEREO_OUT ||
                     i_cfg_index == REG_PHASE_STEP);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sample_depth    <= DEPTH_16;
            r_source_channels <= 2'd1;
            r_stereo_out      <= 1'b0;
            r_phase_step      <= StepW'(ONE_FP);
            r_primed          <= 1'b0;
            r_have_pair       <= 1'b0;
            r_phase           <= '0;
            r_cnt             <= '0;
            r_prev_l          <= '0;
            r_prev_r          <= '0;
            r_next_l          <= '0;
            r_next_r          <= '0;
        end else if (w_cfg_hit) begin
            case (i_cfg_index)
                REG_SAMPLE_DEPTH:    r_sample_depth    <= i_cfg_data[1:0];
                REG_SOURCE_CHANNELS: r_source_channels <= i_cfg_data[1:0];
                REG_STEREO_OUT:      r_stereo_out      <= i_cfg_data[0];
                default:             r_phase_step      <= i_cfg_data[StepW-1:0];
            endcase
            r_primed    <= 1'b0;
            r_have_pair <= 1'b0;
            r_phase     <= '0;
            r_prev_l    <= '0;
            r_prev_r    <= '0;
            r_next_l    <= '0;
            r_next_r    <= '0;
        end else if (i_cmd.load) begin
            r_cnt <= '0;
            if (!r_primed) begin
                r_prev_l <= w_l;
                r_prev_r <= w_r;
                r_next_l <= w_l;
                r_next_r <= w_r;
                r_phase  <= '0;
                r_primed <= 1'b1;
            end else if (!r_have_pair) begin
                r_next_l    <= w_l;
                r_next_r    <= w_r;
                r_have_pair <= 1'b1;
            end else begin
                r_prev_l <= r_next_l;
                r_prev_r <= r_next_r;
                r_next_l <= w_l;
                r_next_r <= w_r;
                r_phase  <= r_phase - ONE_FP;
            end
        end else if (i_cmd.emit) begin
            r_phase <= w_phase_nx;
            r_cnt   <= r_cnt + CntW'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.emit) begin
            r_out_l <= f_lerp(r_prev_l, r_next_l, r_phase[15:8]);
            r_out_r <= r_stereo_out ? f_lerp(r_prev_r, r_next_r, r_phase[15:8]) : 16'sd0;
            r_last  <= (w_phase_nx >= ONE_FP) || (r_cnt == CNT_LAST);
        end
    end

    assign o_status.primed       = r_primed;
    assign o_status.phase_lt_one = (r_phase < ONE_FP);
    assign o_status.last         = r_last;
    assign o_out_left            = r_out_l;
    assign o_out_right           = r_out_r;
    assign o_last                = r_last;

endmodule

/* src/pflr_ctrl.sv */
// Controller: sequences frame load, result generation and output handshake.
`include "pcm_frame_linear_resampler_top_assert.svh"

module pflr_ctrl
    import pflr_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    output logic       o_in_stall,
    output logic       o_out_valid,
    input  logic       i_out_stall,
    input  logic       i_cfg_valid,
    input  t_dp_status i_status,
    output t_dp_cmd    o_cmd
);

    typedef enum logic [1:0] {
        S_IDLE,
        S_CHECK,
        S_OUT
    } t_state;

    t_state r_state;
    logic   r_out_valid;
    logic   w_in_acc;
    logic   w_out_acc;

    always_comb begin
        w_in_acc     = i_in_valid && (r_state == S_IDLE);
        w_out_acc    = r_out_valid && !i_out_stall;
        o_cmd.load   = w_in_acc;
        o_cmd.emit   = ((r_state == S_CHECK) && i_status.phase_lt_one) ||
                       ((r_state == S_OUT) && w_out_acc && !i_status.last);
        o_cmd.cfg_wr = i_cfg_valid;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            unique case (r_state)
                S_IDLE: begin
                    if (w_in_acc && i_status.primed) begin
                        r_state <= S_CHECK;
                    end
                end
                S_CHECK: begin
                    if (i_status.phase_lt_one) begin
                        r_state     <= S_OUT;
                        r_out_valid <= 1'b1;
                    end else begin
                        r_state <= S_IDLE;
                    end
                end
                S_OUT: begin
                    if (w_out_acc && i_status.last) begin
                        r_state     <= S_IDLE;
                        r_out_valid <= 1'b0;
                    end
                end
                default: begin
                    r_state     <= S_IDLE;
                    r_out_valid <= 1'b0;
                end
            endcase
        end
    end

    assign o_in_stall  = (r_state != S_IDLE);
    assign o_out_valid = r_out_valid;

    `PFLR_ASSERT(a_valid_in_out, i_clk, i_rst_n, r_out_valid |-> (r_state == S_OUT), "valid outside output state")
    `PFLR_ASSERT(a_load_to_check, i_clk, i_rst_n, (w_in_acc && i_status.primed) |=> (r_state == S_CHECK), "primed load did not start work")
    `PFLR_ASSERT(a_last_to_idle, i_clk, i_rst_n, (w_out_acc && i_status.last) |=> (r_state == S_IDLE && !r_out_valid), "last word did not end item")
    `PFLR_ASSERT_ALWAYS(a_reset_clears, i_clk, !i_rst_n |=> !r_out_valid, "valid after reset")

endmodule

/* src/pcm_frame_linear_resampler_top.sv */
// Top level of the PCM frame linear resampler.
//
//  channel  direction  handshake             words
//  in       sink       i_in_valid/o_in_stall  i_left_raw, i_right_raw
//  out      source     o_out_valid/i_out_stall o_out_left, o_out_right, o_last
//  cfg      sink       i_cfg_valid/o_cfg_ready i_cfg_index, i_cfg_data
//
// A frame is loaded and its phase checked, then the left and right lerp multipliers
// give one interpolated word per cycle while the output is not stalled. A priming
// frame is only loaded; a frame with no result is loaded, checked and dropped.
// Input is stalled from the load until the last word is taken. Reset is
// synchronous, active low, and restores register defaults and clears state.
module pcm_frame_linear_resampler_top
    import pflr_pkg::*;
(
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_stall,
    input  logic [31:0]         i_left_raw,
    input  logic [31:0]         i_right_raw,
    output logic                o_out_valid,
    input  logic                i_out_stall,
    output logic signed [15:0]  o_out_left,
    output logic signed [15:0]  o_out_right,
    output logic                o_last,
    input  logic                i_cfg_valid,
    output logic                o_cfg_ready,
    input  logic [CfgIdxW-1:0]  i_cfg_index,
    input  logic [CfgDataW-1:0] i_cfg_data
);

    t_dp_cmd    w_cmd;
    t_dp_status w_status;

    pflr_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .i_cfg_valid (i_cfg_valid),
        .i_status    (w_status),
        .o_cmd       (w_cmd)
    );

    pflr_datapath u_datapath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (w_cmd),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_left_raw  (i_left_raw),
        .i_right_raw (i_right_raw),
        .o_status    (w_status),
        .o_out_left  (o_out_left),
        .o_out_right (o_out_right),
        .o_last      (o_last)
    );

    assign o_cfg_ready = 1'b1;

endmodule

/* tb/pcm_frame_linear_resampler_top_tb.sv */
// Self-checking testbench of the PCM frame linear resampler top level.
`timescale 1ns / 1ps

module pcm_frame_linear_resampler_top_tb;
    import pflr_pkg::*;

    typedef struct packed {
        logic signed [15:0] left;
        logic signed [15:0] right;
        logic               last;
    } t_out_word;

    class t_resample_tracker;
        logic [1:0]         depth;
        logic [1:0]         chans;
        logic               stereo;
        logic [StepW-1:0]   step;
        logic               primed;
        logic               have_pair;
        logic [PhaseW-1:0]  phase;
        logic signed [15:0] prev_l, prev_r, next_l, next_r;
        t_out_word          due_words[$];
        int                 errors;

        function new();
            errors = 0;
            set_defaults();
        endfunction

        function void set_defaults();
            depth  = DEPTH_16;
            chans  = 2'd1;
            stereo = 1'b0;
            step   = 22'd65536;
            clear();
        endfunction

        function void clear();
            primed    = 1'b0;
            have_pair = 1'b0;
            phase     = '0;
            prev_l    = '0;
            prev_r    = '0;
            next_l    = '0;
            next_r    = '0;
        endfunction

        function void write_reg(logic [CfgIdxW-1:0] idx, logic [CfgDataW-1:0] data);
            case (idx)
                REG_SAMPLE_DEPTH:    depth  = data[1:0];
                REG_SOURCE_CHANNELS: chans  = data[1:0];
                REG_STEREO_OUT:      stereo = data[0];
                REG_PHASE_STEP:      step   = data[StepW-1:0];
                default:             return;
            endcase
            clear();
        endfunction

        function logic signed [15:0] decode(logic [31:0] raw);
            case (depth)
                DEPTH_8:  return {~raw[7], raw[6:0], 8'h00};
                DEPTH_24: return raw[23:8];
                DEPTH_32: return raw[31:16];
                default:  return raw[15:0];
            endcase
        endfunction

        // p + floor((n - p) * t / 256)
        function logic signed [15:0] lerp(logic signed [15:0] p, logic signed [15:0] n, int t);
            int x;
            x = (int'(n) - int'(p)) * t;
            return 16'(int'(p) + (x >>> 8));
        endfunction

        function void take_frame(logic [31:0] l_raw, logic [31:0] r_raw);
            logic signed [15:0] a, b;
            logic [StepW-1:0]   eff;
            t_out_word          w;
            int                 n;
            int                 t;
            n   = 0;
            eff = (step < MIN_STEP) ? MIN_STEP : step;
            a   = decode(l_raw);
            b   = a;
            if (chans[1]) begin
                b = decode(r_raw);
                if (!stereo) begin
                    a = 16'((int'(a) + int'(b)) / 2);
                    b = a;
                end
            end
            if (!primed) begin
                prev_l = a;
                next_l = a;
                prev_r = b;
                next_r = b;
                phase  = '0;
                primed = 1'b1;
                return;
            end
            if (!have_pair) begin
                next_l    = a;
                next_r    = b;
                have_pair = 1'b1;
            end else begin
                prev_l = next_l;
                prev_r = next_r;
                next_l = a;
                next_r = b;
                phase  = phase - ONE_FP;
            end
            while (phase < ONE_FP && n < 64) begin
                t       = int'(phase[15:8]);
                w.left  = lerp(prev_l, next_l, t);
                w.right = stereo ? lerp(prev_r, next_r, t) : 16'sd0;
                w.last  = 1'b0;
                due_words.push_back(w);
                n++;
                phase = phase + {1'b0, eff};
            end
            if (n > 0)
                due_words[due_words.size() - 1].last = 1'b1;
        endfunction

        function void check_word(logic signed [15:0] ol, logic signed [15:0] orr, logic lst);
            t_out_word e;
            if (due_words.size() == 0) begin
                $error("unexpected output word: out_left=%0d out_right=%0d last=%0d",
                       ol, orr, lst);
                errors++;
                return;
            end
            e = due_words.pop_front();
            if (e.left !== ol) begin
                $error("out_left mismatch: expected %0d, actual %0d", e.left, ol);
                errors++;
            end
            if (e.right !== orr) begin
                $error("out_right mismatch: expected %0d, actual %0d", e.right, orr);
                errors++;
            end
            if (e.last !== lst) begin
                $error("last mismatch: expected %0d, actual %0d", e.last, lst);
                errors++;
            end
        endfunction
    endclass

    logic                i_clk = 1'b0;
    logic                i_rst_n = 1'b0;
    logic                i_in_valid = 1'b0;
    logic                o_in_stall;
    logic [31:0]         i_left_raw = '0;
    logic [31:0]         i_right_raw = '0;
    logic                o_out_valid;
    logic                i_out_stall = 1'b0;
    logic signed [15:0]  o_out_left;
    logic signed [15:0]  o_out_right;
    logic                o_last;
    logic                i_cfg_valid = 1'b0;
    logic                o_cfg_ready;
    logic [CfgIdxW-1:0]  i_cfg_index = '0;
    logic [CfgDataW-1:0] i_cfg_data = '0;

    logic              quiet = 1'b0;
    t_resample_tracker tracker = new();

    pcm_frame_linear_resampler_top i_dut (.*);

    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    always @(negedge i_clk) begin
        i_out_stall <= !quiet && ($urandom_range(99) < 11);
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && !i_out_stall)
            tracker.check_word(o_out_left, o_out_right, o_last);
    end

    task automatic send_frame(input logic [31:0] l, input logic [31:0] r);
        while (!quiet && $urandom_range(99) < 11) begin
            @(negedge i_clk);
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        @(negedge i_clk);
        i_in_valid  <= 1'b1;
        i_left_raw  <= l;
        i_right_raw <= r;
        do @(posedge i_clk); while (o_in_stall);
        tracker.take_frame(l, r);
    endtask

    // Idle the sender until every predicted word is out, then let trailing work finish.
    task automatic drain();
        @(negedge i_clk);
        i_in_valid <= 1'b0;
        while (tracker.due_words.size() != 0)
            @(posedge i_clk);
        repeat (8) @(posedge i_clk);
    endtask

    task automatic cfg_write(input logic [CfgIdxW-1:0] idx, input logic [CfgDataW-1:0] data);
        @(negedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        do @(posedge i_clk); while (!o_cfg_ready);
        tracker.write_reg(idx, data);
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    // Unused upper data bits carry junk.
    task automatic configure(input logic [1:0] depth, input logic [1:0] chans,
                             input logic stereo, input logic [StepW-1:0] step);
        cfg_write(REG_SAMPLE_DEPTH, ($urandom() & ~32'h3) | 32'(depth));
        cfg_write(REG_SOURCE_CHANNELS, ($urandom() & ~32'h3) | 32'(chans));
        cfg_write(REG_STEREO_OUT, ($urandom() & ~32'h1) | 32'(stereo));
        cfg_write(REG_PHASE_STEP, ($urandom() & ~32'h3F_FFFF) | 32'(step));
    endtask

    function automatic logic [31:0] rand_word();
        case ($urandom_range(7))
            0:       return 32'h0000_0000;
            1:       return 32'hFFFF_FFFF;
            2:       return 32'h8080_8080;
            3:       return 32'h7F7F_7F7F;
            default: return $urandom();
        endcase
    endfunction

    function automatic logic [StepW-1:0] rand_step();
        case ($urandom_range(9))
            0:       return StepW'($urandom_range(0, 1023));
            1:       return 22'h3F_FFFF;
            2, 3:    return StepW'($urandom_range(1024, 16384));
            4, 5, 6: return StepW'($urandom_range(16384, 131072));
            7:       return StepW'($urandom_range(131072, 3145728));
            8:       return 22'd65536;
            default: return StepW'($urandom());
        endcase
    endfunction

    initial begin
        int sent;
        int len;
        int ph;
        sent = 0;
        ph   = 0;
        repeat (3) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // reset defaults: 16 bit mono, unity step
        send_frame(32'hA5A5_7FFF, $urandom());
        send_frame(32'hFFFF_8000, $urandom());
        send_frame(32'h1234_0000, $urandom());
        send_frame(32'h0000_FFFF, $urandom());
        drain();

        // 8 bit stereo, 2x upsampling
        configure(DEPTH_8, 2'd2, 1'b1, 22'd32768);
        send_frame(32'h0000_00FF, 32'h0000_0000);
        send_frame(32'h0000_0000, 32'h0000_00FF);
        send_frame(32'hFFFF_FF80, 32'h0000_007F);
        send_frame(32'hFFFF_FF01, 32'h1234_5680);
        drain();

        // 24 bit stereo to mono, averaging, smallest legal step
        configure(DEPTH_24, 2'd2, 1'b0, 22'd1024);
        send_frame(32'h0080_0000, 32'h007F_FF00);
        send_frame(32'h00FF_FF00, 32'h0000_0000);
        send_frame(32'hFFFF_FFFF, 32'hFF80_00FF);
        drain();

        // channel count zero, step below the floor
        configure(DEPTH_32, 2'd0, 1'b1, 22'd0);
        send_frame(32'h7FFF_0000, $urandom());
        send_frame(32'h8000_FFFF, $urandom());
        drain();

        // channel count three, strong downsampling
        configure(DEPTH_16, 2'd3, 1'b1, 22'd3145728);
        repeat (6) send_frame(rand_word(), rand_word());
        drain();

        // writes past the register list leave the state alone
        cfg_write(8'd4, $urandom());
        cfg_write(8'hFF, $urandom());
        repeat (3) send_frame(rand_word(), rand_word());
        drain();

        while (sent < 280) begin
            if ($urandom_range(3) == 0)
                cfg_write(CfgIdxW'($urandom_range(4, 255)), $urandom());
            configure(2'($urandom_range(3)), 2'($urandom_range(3)), 1'($urandom_range(1)),
                      rand_step());
            quiet = (ph == 3);
            len = $urandom_range(8, 40);
            for (int i = 0; i < len; i++) begin
                send_frame(rand_word(), rand_word());
                sent++;
                if ($urandom_range(49) == 0)
                    drain();
            end
            drain();
            quiet = 1'b0;
            ph++;
        end

        drain();
        if (tracker.errors == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

    initial begin
        #5_000_000;
        $display("CHECK FAILED");
        $finish;
    end

endmodule

/* filelist.f */
+incdir+src
src/pflr_pkg.sv
src/pflr_datapath.sv
src/pflr_ctrl.sv
src/pcm_frame_linear_resampler_top.sv
tb/pcm_frame_linear_resampler_top_tb.sv
